[hw/rtl/binomial_coefficient_engine_assert.svh]
// assertion macros for the binomial coefficient engine
// used by the top level only, no other dependencies
`ifndef BINOMIAL_COEFFICIENT_ENGINE_ASSERT_SVH
`define BINOMIAL_COEFFICIENT_ENGINE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BCE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled during reset
`define BCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/bce_pkg.sv]
// shared types and constants for the binomial coefficient engine
// no dependencies
package bce_pkg;

  localparam int unsigned MaxN     = 63;
  localparam int unsigned InW      = 6;
  localparam int unsigned ValueW   = 64;
  localparam int unsigned StepW    = 7;
  localparam int unsigned MulW     = ValueW + StepW;
  localparam int unsigned WideW    = 72;
  localparam int unsigned RemW     = StepW - 1;
  localparam int unsigned CntW     = 7;
  localparam logic [CntW-1:0] DivLast = CntW'(WideW - 1);

  typedef enum logic [1:0] {
    StIdle,
    StLoop,
    StDiv,
    StWb
  } bce_state_e;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic mul;
    logic div;
    logic commit;
    logic emit;
  } bce_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic err;
    logic more;
    logic div_last;
    logic out_busy;
  } bce_stat_t;

endpackage

[hw/rtl/bce_if.sv]
// valid/ready channel interfaces for the binomial coefficient engine
// depends on bce_pkg
interface bce_in_if;
  logic                      valid;
  logic                      ready;
  logic [bce_pkg::InW-1:0]   n;
  logic [bce_pkg::InW-1:0]   k;

  modport source (output valid, output n, output k, input ready);
  modport sink   (input valid, input n, input k, output ready);
endinterface

interface bce_out_if;
  logic                        valid;
  logic                        ready;
  logic [bce_pkg::ValueW-1:0]  value;
  logic                        error;

  modport source (output valid, output value, output error, input ready);
  modport sink   (input valid, input value, input error, output ready);
endinterface

[hw/rtl/binomial_coefficient_engine.sv]
// binomial coefficient engine: C(n,k) by the multiplicative rule
// depends on bce_pkg, bce_if, bce_controller, bce_datapath and the assert header
//
// usage:
// - in_i carries n and k; a transfer happens when valid and ready are both high
// - res_o carries value and error; error is set with value 0 when k > n
// - ready on in_i is high only while the engine is idle; one item at a time
// - each step i = 1..k multiplies the product by n+1-i and then divides
//   it by i with the restoring divider
// - the divider loop sets the rate; a 64x7 multiplier is the widest logic
// - the result sits in an output register, so a stalled receiver only holds
//   the engine once it has a second result ready to write back
// - reset clears the controller, the result valid flag and the working state
`include "binomial_coefficient_engine_assert.svh"

module binomial_coefficient_engine (
  input logic         clk_i,
  input logic         rst_ni,
  bce_in_if.sink      in_i,
  bce_out_if.source   res_o
);

  bce_pkg::bce_cmd_t   cmd;
  bce_pkg::bce_stat_t  stat;
  bce_pkg::bce_state_e state;

  // sequencing: accept, loop over steps, write back
  bce_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  // arithmetic and the result register
  bce_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .n_i         (in_i.n),
    .k_i         (in_i.k),
    .stat_o      (stat),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .value_o     (res_o.value),
    .error_o     (res_o.error)
  );

  // an accepted item keeps the engine busy for at least the next cycle
  `BCE_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)

  // an error result always carries a zero value
  `BCE_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, res_o.valid && res_o.error, res_o.value == '0)

  // the divider only runs on a valid pair with a step still to do
  `BCE_ASSERT_IMPL(a_div_in_range, clk_i, rst_ni, state == bce_pkg::StDiv,
                   stat.more && !stat.err)

endmodule

[hw/rtl/bce_controller.sv]
// sequencing state machine for the binomial coefficient engine
// depends on bce_pkg
module bce_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bce_pkg::bce_stat_t  stat_i,
  output bce_pkg::bce_cmd_t   cmd_o,
  output bce_pkg::bce_state_e state_o
);

  bce_pkg::bce_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bce_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bce_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = bce_pkg::StLoop;
        end
      end
      bce_pkg::StLoop: begin
        if (stat_i.err || !stat_i.more) begin
          state_d = bce_pkg::StWb;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = bce_pkg::StDiv;
        end
      end
      bce_pkg::StDiv: begin
        cmd_o.div = 1'b1;
        if (stat_i.div_last) begin
          cmd_o.commit = 1'b1;
          state_d      = bce_pkg::StLoop;
        end
      end
      bce_pkg::StWb: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = bce_pkg::StIdle;
        end
      end
      default: state_d = bce_pkg::StIdle;
    endcase
  end

  assign state_o = state_q;

endmodule

[hw/rtl/bce_datapath.sv]
// product, multiplier, bit-serial divider and result register
// depends on bce_pkg
module bce_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bce_pkg::bce_cmd_t           cmd_i,
  input  logic [bce_pkg::InW-1:0]     n_i,
  input  logic [bce_pkg::InW-1:0]     k_i,
  output bce_pkg::bce_stat_t          stat_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [bce_pkg::ValueW-1:0]  value_o,
  output logic                        error_o
);

  logic [bce_pkg::InW-1:0]    n_q, k_q;
  logic                       err_q;
  logic [bce_pkg::ValueW-1:0] prod_q;
  logic [bce_pkg::StepW-1:0]  step_q;
  logic [bce_pkg::WideW-1:0]  wide_q;
  logic [bce_pkg::RemW-1:0]   rem_q;
  logic [bce_pkg::CntW-1:0]   cnt_q;
  logic                       out_valid_q;
  logic [bce_pkg::ValueW-1:0] value_q;
  logic                       error_q;

  logic [bce_pkg::StepW-1:0]  m_w;
  logic [bce_pkg::MulW-1:0]   mul_w;
  logic [bce_pkg::StepW-1:0]  trial_w;
  logic                       ge_w;
  logic [bce_pkg::StepW-1:0]  diff_w;
  logic                       bad_w;

  // m = n + 1 - i
  assign m_w   = bce_pkg::StepW'({1'b0, n_q}) + bce_pkg::StepW'(1) - step_q;
  assign mul_w = prod_q * m_w;

  // restoring division, one quotient bit a cycle
  assign trial_w = {rem_q, wide_q[bce_pkg::WideW-1]};
  assign ge_w    = (trial_w >= step_q);
  assign diff_w  = trial_w - step_q;

  assign bad_w = (k_i > n_i) || ({1'b0, n_i} > bce_pkg::StepW'(bce_pkg::MaxN));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q       <= 1'b0;
      prod_q      <= '0;
      step_q      <= '0;
      wide_q      <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        err_q <= bad_w;
        if (!bad_w) begin
          prod_q <= bce_pkg::ValueW'(1);
          step_q <= bce_pkg::StepW'(1);
        end
      end
      if (cmd_i.mul) begin
        wide_q <= bce_pkg::WideW'(mul_w);
        rem_q  <= '0;
        cnt_q  <= '0;
      end
      if (cmd_i.div) begin
        wide_q <= {wide_q[bce_pkg::WideW-2:0], ge_w};
        rem_q  <= ge_w ? diff_w[bce_pkg::RemW-1:0] : trial_w[bce_pkg::RemW-1:0];
        cnt_q  <= cnt_q + bce_pkg::CntW'(1);
      end
      if (cmd_i.commit) begin
        // last quotient bit shifts in this cycle
        prod_q <= {wide_q[bce_pkg::ValueW-2:0], ge_w};
        step_q <= step_q + bce_pkg::StepW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      n_q <= n_i;
      k_q <= k_i;
    end
    if (cmd_i.emit) begin
      value_q <= err_q ? '0 : prod_q;
      error_q <= err_q;
    end
  end

  assign stat_o.err      = err_q;
  assign stat_o.more     = (step_q <= {1'b0, k_q});
  assign stat_o.div_last = (cnt_q == bce_pkg::DivLast);
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign error_o     = error_q;

endmodule
